/* src/slcf_pkg.sv */
// ----------------------------------------------------------------------------
// slcf_pkg: shared definitions for the same-length complex FIR
// Default parameter values, fixed field widths, command codes, the controller
// state type and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package slcf_pkg;

  localparam int MAX_TAPS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed widths of the configuration register and the tap index field.
  localparam int CFG_BITS       = 6;
  localparam int TAP_INDEX_BITS = 5;

  // Input word kinds.
  localparam logic CMD_TAP    = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MAC   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_PUSH  = 6'b010000,
    S_NEXT  = 6'b100000
  } slcf_state_t;

  typedef struct packed {
    logic tap_we;     // write the input word into the tap store
    logic shift;      // shift the sample history by one
    logic shift_zero; // the shifted-in value is zero (tail flush)
    logic clear;      // zero the whole history at block end
    logic mac_issue;  // one multiply-accumulate step enters the pipeline
    logic mac_first;  // this step starts a new sum
    logic load_out;   // capture the rounded sum in the output register
    logic out_last;   // value of the last flag for the captured result
  } slcf_cmd_t;

endpackage

/* src/slcf_ifs.sv */
// ----------------------------------------------------------------------------
// slcf_ifs: stream channels of the same-length complex FIR
// One interface for input words (taps or samples), one for result words.
// ----------------------------------------------------------------------------
interface slcf_in_if import slcf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [TAP_INDEX_BITS-1:0]        tap_index;
  logic signed [SAMPLE_BITS-1:0]    data_re;
  logic signed [SAMPLE_BITS-1:0]    data_im;
  logic                             block_last;

  modport source (output valid, cmd, tap_index, data_re, data_im, block_last,
                  input ready);
  modport sink   (input valid, cmd, tap_index, data_re, data_im, block_last,
                  output ready);
endinterface

interface slcf_out_if import slcf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_BITS-1:0]    out_re;
  logic signed [SAMPLE_BITS-1:0]    out_im;
  logic                             out_last;
  logic                             out_saturated;

  modport source (output valid, out_re, out_im, out_last, out_saturated,
                  input ready);
  modport sink   (input valid, out_re, out_im, out_last, out_saturated,
                  output ready);
endinterface

/* src/same_length_complex_fir.sv */
// ----------------------------------------------------------------------------
// same_length_complex_fir: complex FIR with output block as long as the input
// Top level joining the sequencer and the datapath to the stream channels.
// ----------------------------------------------------------------------------
// A tap word (cmd 0) writes one complex tap. A sample word (cmd 1) produces
// y[n] = sum of x[n+k-M/2]*h[k] once the (M-1)/2 samples of lookahead have
// arrived; the word marked block_last also flushes the delayed tail, so it
// yields up to (M-1)/2+1 results. Every result is computed by one shared
// complex multiply-accumulate unit, one tap per cycle, and a new input word
// is taken only once the sequencer has finished every step of the sample
// word before it. A result waits while the output register still holds an
// untaken word. Results are rounded half up and clipped to Q1.15, with
// out_saturated set on clipping. The output register lets the next input
// word be accepted while the last result of the previous one still waits on
// the output side. The tap count may be written only while the block is idle;
// taps must be written before they are used.
// ----------------------------------------------------------------------------
module same_length_complex_fir import slcf_pkg::*; #(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  slcf_in_if.sink             in_ch,
  slcf_out_if.source          out_ch
);

  localparam int HW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  slcf_cmd_t     cmd;
  logic [HW-1:0] tap_addr;
  logic [HW-1:0] hist_idx;

  // The sequencer owns both handshakes; the datapath holds every output payload bit.
  slcf_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_cmd        (in_ch.cmd),
    .in_tap_index  (in_ch.tap_index),
    .in_block_last (in_ch.block_last),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .cmd           (cmd),
    .tap_addr      (tap_addr),
    .hist_idx      (hist_idx)
  );

  // Taps, history, multiply-accumulate pipeline and the output word register.
  slcf_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .tap_index     (in_ch.tap_index),
    .data_re       (in_ch.data_re),
    .data_im       (in_ch.data_im),
    .tap_addr      (tap_addr),
    .hist_idx      (hist_idx),
    .out_re        (out_ch.out_re),
    .out_im        (out_ch.out_im),
    .out_last      (out_ch.out_last),
    .out_saturated (out_ch.out_saturated)
  );

endmodule

/* src/slcf_ram.sv */
// ----------------------------------------------------------------------------
// slcf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module slcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/slcf_datapath.sv */
// ----------------------------------------------------------------------------
// slcf_datapath: storage and arithmetic of the same-length complex FIR
// Tap store, sample history shift line, a pipelined complex multiply-
// accumulate unit and the rounding and saturating output register.
// ----------------------------------------------------------------------------
module slcf_datapath import slcf_pkg::*; #(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int HW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  slcf_cmd_t                     cmd,
  input  logic [TAP_INDEX_BITS-1:0]     tap_index,
  input  logic signed [SAMPLE_BITS-1:0] data_re,
  input  logic signed [SAMPLE_BITS-1:0] data_im,
  input  logic [HW-1:0]                 tap_addr,
  input  logic [HW-1:0]                 hist_idx,
  output logic signed [SAMPLE_BITS-1:0] out_re,
  output logic signed [SAMPLE_BITS-1:0] out_im,
  output logic                          out_last,
  output logic                          out_saturated
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FRAC  = SB - 1;
  localparam int PW    = 2 * SB;
  localparam int ACC_W = PW + 2 + HW;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (FRAC - 1));

  // Tap store
  logic [PW-1:0] tap_rdata;

  slcf_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk   (clk),
    .we    (cmd.tap_we),
    .waddr (HW'(tap_index)),
    .wdata ({data_re, data_im}),
    .raddr (tap_addr),
    .rdata (tap_rdata)
  );

  // Sample history, newest at index zero
  logic signed [SB-1:0] hist_re_r [MAX_TAPS];
  logic signed [SB-1:0] hist_im_r [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_re_r[i] <= '0;
        hist_im_r[i] <= '0;
      end
    end else if (cmd.shift) begin
      for (int i = MAX_TAPS - 1; i > 0; i--) begin
        hist_re_r[i] <= hist_re_r[i-1];
        hist_im_r[i] <= hist_im_r[i-1];
      end
      hist_re_r[0] <= cmd.shift_zero ? '0 : data_re;
      hist_im_r[0] <= cmd.shift_zero ? '0 : data_im;
    end
  end

  // Stage 1: operands registered (the tap comes out of the RAM register).
  logic                 v1_r, first1_r;
  logic signed [SB-1:0] xr_r, xi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      first1_r <= 1'b0;
    end else begin
      v1_r     <= cmd.mac_issue;
      first1_r <= cmd.mac_first;
    end
    xr_r <= hist_re_r[hist_idx];
    xi_r <= hist_im_r[hist_idx];
  end

  logic signed [SB-1:0] hr, hi;
  assign hr = $signed(tap_rdata[PW-1:SB]);
  assign hi = $signed(tap_rdata[SB-1:0]);

  // Stage 2: the four partial products.
  logic                 v2_r, first2_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r     <= 1'b0;
      first2_r <= 1'b0;
    end else begin
      v2_r     <= v1_r;
      first2_r <= first1_r;
    end
    p_rr_r <= xr_r * hr;
    p_ii_r <= xi_r * hi;
    p_ri_r <= xr_r * hi;
    p_ir_r <= xi_r * hr;
  end

  // Stage 3: accumulate.
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] acc_re_base, acc_im_base;

  assign acc_re_base = first2_r ? '0 : acc_re_r;
  assign acc_im_base = first2_r ? '0 : acc_im_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_re_r <= acc_re_base + ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
      acc_im_r <= acc_im_base + ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
    end
  end

  // Round half up, then clip to the sample range.
  function automatic logic [SB:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] r;
    sum = acc + HALF;
    r   = sum >>> FRAC;
    if (r > SAT_HI) begin
      round_sat = {1'b1, SAT_HI[SB-1:0]};
    end else if (r < SAT_LO) begin
      round_sat = {1'b1, SAT_LO[SB-1:0]};
    end else begin
      round_sat = {1'b0, r[SB-1:0]};
    end
  endfunction

  logic [SB:0] rs_re, rs_im;
  assign rs_re = round_sat(acc_re_r);
  assign rs_im = round_sat(acc_im_r);

  logic signed [SB-1:0] out_re_r, out_im_r;
  logic                 out_last_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_re_r   <= $signed(rs_re[SB-1:0]);
      out_im_r   <= $signed(rs_im[SB-1:0]);
      out_last_r <= cmd.out_last;
      out_sat_r  <= rs_re[SB] | rs_im[SB];
    end
  end

  assign out_re        = out_re_r;
  assign out_im        = out_im_r;
  assign out_last      = out_last_r;
  assign out_saturated = out_sat_r;

endmodule

/* src/slcf_ctrl.sv */
// ----------------------------------------------------------------------------
// slcf_ctrl: sequencer of the same-length complex FIR
// Holds the tap count, fill count and flush position, walks the taps of each
// output through the datapath and hands results to the output register.
// ----------------------------------------------------------------------------
module slcf_ctrl import slcf_pkg::*; #(
  parameter int MAX_TAPS = MAX_TAPS_DEF,
  localparam int HW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int MW = $clog2(MAX_TAPS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_BITS-1:0]       cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [TAP_INDEX_BITS-1:0] in_tap_index,
  input  logic                      in_block_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output slcf_cmd_t                 cmd,
  output logic [HW-1:0]             tap_addr,
  output logic [HW-1:0]             hist_idx
);

  localparam int FW = MW;
  localparam int LW = HW;

  slcf_state_t          state_r, state_nxt;
  logic [CFG_BITS-1:0]  tap_count_r;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [MW-1:0]        m_r, m_nxt;
  logic [LW-1:0]        lag_r, lag_nxt;
  logic [LW-1:0]        j_r, j_nxt;
  logic [HW-1:0]        k_r, k_nxt;
  logic                 last_r, last_nxt;
  logic                 elast_r, elast_nxt;
  logic                 drain_r, drain_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Taps in use: zero counts as one, anything beyond the store is clipped.
  logic [MW-1:0] m_cur;
  logic [LW-1:0] lag_cur;

  always_comb begin
    if (32'(tap_count_r) > 32'(MAX_TAPS)) begin
      m_cur = MW'(MAX_TAPS);
    end else if (tap_count_r == '0) begin
      m_cur = MW'(1);
    end else begin
      m_cur = MW'(tap_count_r);
    end
    lag_cur = LW'((m_cur - MW'(1)) >> 1);
  end

  logic          out_free;
  logic [FW-1:0] fill_inc;

  assign out_free = !out_valid_r || out_ready;
  assign fill_inc = (32'(fill_r) < 32'(MAX_TAPS)) ? fill_r + FW'(1) : fill_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    m_nxt     = m_r;
    lag_nxt   = lag_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    elast_nxt = elast_r;
    drain_nxt = drain_r;
    cmd       = '0;
    in_ready  = 1'b0;
    tap_addr  = k_r;
    hist_idx  = HW'(m_r - MW'(1) - MW'(k_r));

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_TAP) begin
            cmd.tap_we = (32'(in_tap_index) < 32'(MAX_TAPS));
          end else begin
            cmd.shift = 1'b1;
            fill_nxt  = fill_inc;
            m_nxt     = m_cur;
            lag_nxt   = lag_cur;
            last_nxt  = in_block_last;
            elast_nxt = in_block_last && (lag_cur == '0);
            j_nxt     = '0;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (fill_r > FW'(lag_r)) begin
          k_nxt     = '0;
          state_nxt = S_MAC;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.mac_first = (k_r == '0);
        if (MW'(k_r) == m_r - MW'(1)) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + HW'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = elast_r;
          state_nxt    = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_r && (j_r < lag_r)) begin
          cmd.shift      = 1'b1;
          cmd.shift_zero = 1'b1;
          fill_nxt       = fill_inc;
          elast_nxt      = ((LW + 1)'(j_r) + (LW + 1)'(1) == (LW + 1)'(lag_r));
          j_nxt          = j_r + LW'(1);
          state_nxt      = S_CHECK;
        end else begin
          if (last_r) begin
            cmd.clear = 1'b1;
            fill_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_count_r <= CFG_BITS'(1);
      fill_r      <= '0;
      m_r         <= MW'(1);
      lag_r       <= '0;
      j_r         <= '0;
      k_r         <= '0;
      last_r      <= 1'b0;
      elast_r     <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      m_r         <= m_nxt;
      lag_r       <= lag_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      last_r      <= last_nxt;
      elast_r     <= elast_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(MAX_TAPS))
    else $error("fill count beyond history depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken word");

  a_mac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> ((MW'(k_r) < m_r) && (fill_r > FW'(lag_r))))
    else $error("tap step outside the filter or before enough samples");

  a_mac_to_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC && state_nxt == S_DRAIN) |=> ##1 (state_r == S_DRAIN))
    else $error("accumulator drain shorter than pipeline");
`endif

endmodule

/* tb/same_length_complex_fir_test.sv */
// ----------------------------------------------------------------------------
// same_length_complex_fir_test: self-checking bench for the same-length FIR
// Streams tap and sample words through the filter with random pauses on both
// channels. A behavioral copy of the filter predicts every filtered word, and
// each word that leaves the block is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module same_length_complex_fir_test;
  import slcf_pkg::*;

  localparam int NTAPS         = MAX_TAPS_DEF;
  localparam int SW            = SAMPLE_BITS_DEF;
  localparam int RANDOM_WORDS  = 370;
  // Quiet cycles after the last expected word before a register write or the
  // verdict, so that a tap word or a sample word that yields nothing can finish.
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int PRINT_LIMIT   = 60;

  typedef logic signed [SW-1:0] q15_t;

  // One input word: a tap load or a sample.
  typedef struct {
    logic                      cmd;
    logic [TAP_INDEX_BITS-1:0] tap_index;
    q15_t                      re;
    q15_t                      im;
    logic                      last;
  } fir_word_t;

  // One filtered output word.
  typedef struct {
    q15_t re;
    q15_t im;
    logic last;
    logic sat;
  } fir_y_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  slcf_in_if  #(.SAMPLE_BITS(SW)) in_ch ();
  slcf_out_if #(.SAMPLE_BITS(SW)) out_ch ();

  same_length_complex_fir uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter state as the bench sees it. The history holds the newest sample at
  // position 0; fill_count saturates at the history depth.
  // --------------------------------------------------------------------------
  q15_t                tap_re  [NTAPS];
  q15_t                tap_im  [NTAPS];
  q15_t                hist_re [NTAPS];
  q15_t                hist_im [NTAPS];
  int                  fill_count;
  logic [CFG_BITS-1:0] tap_count_reg;

  fir_word_t word_queue [$];   // words waiting to be driven
  fir_y_t    y_queue    [$];   // filtered words still due from the block
  fir_word_t live_word;        // word currently offered on the input channel
  fir_y_t    due_y;

  int words_queued, words_taken, taps_taken, samples_taken, blocks_taken;
  int results_checked, sat_seen, errors, cycles;
  bit in_calm, out_calm;
  int in_gap, out_gap;

  // Push one sample into the history, oldest one falls off the end.
  function automatic void shift_history(q15_t re, q15_t im);
    for (int i = NTAPS - 1; i > 0; i--) begin
      hist_re[i] = hist_re[i-1];
      hist_im[i] = hist_im[i-1];
    end
    hist_re[0] = re;
    hist_im[0] = im;
    if (fill_count < NTAPS) fill_count++;
  endfunction

  // Round half up, then clip to the sample range. The clip flag is sticky
  // across both parts of one output word.
  function automatic q15_t round_clip(longint acc, inout bit clipped);
    longint r;
    r = (acc + (longint'(1) <<< (SW - 2))) >>> (SW - 1);
    if (r > longint'(q15_t'({1'b0, {(SW-1){1'b1}}}))) begin
      r = longint'(q15_t'({1'b0, {(SW-1){1'b1}}}));
      clipped = 1'b1;
    end
    if (r < longint'(q15_t'({1'b1, {(SW-1){1'b0}}}))) begin
      r = longint'(q15_t'({1'b1, {(SW-1){1'b0}}}));
      clipped = 1'b1;
    end
    return q15_t'(r);
  endfunction

  // Exact complex dot product of the newest m history entries with taps
  // 0..m-1 (tap 0 meets the oldest of them, so taps are not reversed).
  function automatic fir_y_t window_sum(int m, bit last);
    longint acc_re, acc_im;
    bit     clipped;
    int     age;
    fir_y_t y;
    acc_re  = 0;
    acc_im  = 0;
    clipped = 1'b0;
    for (int k = 0; k < m; k++) begin
      age = m - 1 - k;
      acc_re += longint'(hist_re[age]) * tap_re[k] - longint'(hist_im[age]) * tap_im[k];
      acc_im += longint'(hist_re[age]) * tap_im[k] + longint'(hist_im[age]) * tap_re[k];
    end
    y.re   = round_clip(acc_re, clipped);
    y.im   = round_clip(acc_im, clipped);
    y.last = last;
    y.sat  = clipped;
    return y;
  endfunction

  // Advance the filter by one accepted word and queue what it must produce.
  // An output leaves once its (M-1)/2 samples of lookahead are in; the word
  // that closes a block pushes zeros to flush the delayed tail and then
  // clears the history for the next block.
  function automatic void fir_step(fir_word_t w);
    int m, lag;
    if (w.cmd == CMD_TAP) begin
      tap_re[w.tap_index] = w.re;
      tap_im[w.tap_index] = w.im;
      return;
    end
    m = int'(tap_count_reg);
    if (m < 1) m = 1;
    if (m > NTAPS) m = NTAPS;
    lag = (m - 1) / 2;
    shift_history(w.re, w.im);
    if (fill_count > lag) y_queue.push_back(window_sum(m, w.last && lag == 0));
    if (w.last) begin
      for (int j = 0; j < lag; j++) begin
        shift_history('0, '0);
        if (fill_count > lag) y_queue.push_back(window_sum(m, j + 1 == lag));
      end
      for (int i = 0; i < NTAPS; i++) begin
        hist_re[i] = '0;
        hist_im[i] = '0;
      end
      fill_count = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Sample or tap value: full-scale extremes, values near zero and anything.
  function automatic q15_t pick_q15();
    case ($urandom_range(0, 7))
      0:       return q15_t'({1'b1, {(SW-1){1'b0}}});
      1:       return q15_t'({1'b0, {(SW-1){1'b1}}});
      2:       return q15_t'($urandom_range(0, 64)) - q15_t'(32);
      default: return q15_t'($urandom);
    endcase
  endfunction

  // Pause before the next word on one side. Each side drifts between calm
  // stretches with no pauses and busy stretches with randomly drawn pauses.
  function automatic int draw_pause(inout bit calm);
    if ($urandom_range(0, 47) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  task automatic queue_tap(int idx, q15_t re, q15_t im, bit last);
    fir_word_t w;
    w.cmd       = CMD_TAP;
    w.tap_index = TAP_INDEX_BITS'(idx);
    w.re        = re;
    w.im        = im;
    w.last      = last;
    word_queue.push_back(w);
    words_queued++;
  endtask

  task automatic queue_sample(q15_t re, q15_t im, bit last);
    fir_word_t w;
    w.cmd       = CMD_SAMPLE;
    w.tap_index = TAP_INDEX_BITS'($urandom);   // unused on a sample
    w.re        = re;
    w.im        = im;
    w.last      = last;
    word_queue.push_back(w);
    words_queued++;
  endtask

  // Wait until every queued word was taken and every predicted word arrived,
  // then wait out SETTLE_CYCLES so that any word yielding nothing can finish.
  task automatic drain();
    while (words_taken != words_queued || y_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_count(int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_BITS'(v);
    @(posedge clk);
    tap_count_reg = CFG_BITS'(v);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Input driver. A word is taken at an edge where valid and ready are both
  // high; that is where the prediction advances. After each taken word the
  // driver may hold valid low for a drawn number of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.cmd        <= CMD_TAP;
      in_ch.tap_index  <= '0;
      in_ch.data_re    <= '0;
      in_ch.data_im    <= '0;
      in_ch.block_last <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        fir_step(live_word);
        words_taken++;
        if (live_word.cmd == CMD_TAP) begin
          taps_taken++;
        end else begin
          samples_taken++;
          if (live_word.last) blocks_taken++;
        end
        in_gap = draw_pause(in_calm);
      end
      // The channel is free if nothing was offered or the offer was just taken.
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (word_queue.size() != 0) begin
          live_word = word_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.cmd        <= live_word.cmd;
          in_ch.tap_index  <= live_word.tap_index;
          in_ch.data_re    <= live_word.re;
          in_ch.data_im    <= live_word.im;
          in_ch.block_last <= live_word.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor. Each filtered word taken is matched against the oldest
  // prediction; ready may then drop for a drawn number of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (y_queue.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing due (re %0d im %0d)",
                                    results_checked, out_ch.out_re, out_ch.out_im));
        end else begin
          due_y = y_queue.pop_front();
          if (due_y.sat) sat_seen++;
          if (out_ch.out_re !== due_y.re)
            report_mismatch($sformatf("word %0d out_re %0d, expected %0d",
                                      results_checked, out_ch.out_re, due_y.re));
          if (out_ch.out_im !== due_y.im)
            report_mismatch($sformatf("word %0d out_im %0d, expected %0d",
                                      results_checked, out_ch.out_im, due_y.im));
          if (out_ch.out_last !== due_y.last)
            report_mismatch($sformatf("word %0d out_last %b, expected %b",
                                      results_checked, out_ch.out_last, due_y.last));
          if (out_ch.out_saturated !== due_y.sat)
            report_mismatch($sformatf("word %0d out_saturated %b, expected %b",
                                      results_checked, out_ch.out_saturated, due_y.sat));
        end
        out_gap = draw_pause(out_calm);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words still due", cycles, y_queue.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int m, eff, lag, len, shift, random_end;
    bit open;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;

    // Bench copy of the reset state. Taps stay unknown until written, and the
    // stimulus never reads one before writing it.
    fill_count    = 0;
    tap_count_reg = CFG_BITS'(1);
    for (int i = 0; i < NTAPS; i++) begin
      hist_re[i] = '0;
      hist_im[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Single tap, reset tap count. A tap of -1-j squared against -1-j gives
    // +2j, which must clip high; against full-scale positive it clips low.
    queue_tap(0, q15_t'({1'b1, {(SW-1){1'b0}}}), q15_t'({1'b1, {(SW-1){1'b0}}}), 1'b0);
    queue_sample(q15_t'({1'b1, {(SW-1){1'b0}}}), q15_t'({1'b1, {(SW-1){1'b0}}}), 1'b0);
    queue_sample(q15_t'({1'b0, {(SW-1){1'b1}}}), q15_t'({1'b0, {(SW-1){1'b1}}}), 1'b0);
    queue_sample('0, '0, 1'b0);
    // A tap load in the middle of a block, with its block_last set, must not
    // end the block. The new tap of one half makes exact rounding ties:
    // +1/2 LSB rounds up to 1, -1/2 LSB rounds up to 0.
    queue_tap(0, q15_t'(1 << (SW - 2)), '0, 1'b1);
    queue_sample(q15_t'(1), q15_t'(-1), 1'b0);
    queue_sample(q15_t'(-1), q15_t'(1), 1'b1);

    // A tap count of zero behaves as one tap.
    write_tap_count(0);
    queue_sample(q15_t'(100), q15_t'(-100), 1'b1);

    // Load every tap position once so that any later tap count is safe.
    for (int i = 0; i < NTAPS - 1; i++) queue_tap(i, pick_q15(), pick_q15(), $urandom_range(0, 1));
    queue_tap(NTAPS - 1, q15_t'({1'b0, {(SW-1){1'b1}}}), q15_t'({1'b1, {(SW-1){1'b0}}}), 1'b1);

    // Tap count above the maximum saturates; a 3-sample block is shorter than
    // the lookahead, so all three outputs leave with its last sample.
    write_tap_count(63);
    queue_sample(pick_q15(), pick_q15(), 1'b0);
    queue_sample(pick_q15(), pick_q15(), 1'b0);
    queue_sample(pick_q15(), pick_q15(), 1'b1);

    // Even tap count with no lookahead.
    write_tap_count(2);
    queue_sample(pick_q15(), pick_q15(), 1'b0);
    queue_sample(pick_q15(), pick_q15(), 1'b1);

    // Tap count changed halfway through a block.
    write_tap_count(4);
    queue_sample(pick_q15(), pick_q15(), 1'b0);
    queue_sample(pick_q15(), pick_q15(), 1'b0);
    write_tap_count(5);
    queue_sample(pick_q15(), pick_q15(), 1'b0);
    queue_sample(pick_q15(), pick_q15(), 1'b1);

    // Random phases: a new tap count, sometimes fresh taps, then a few blocks.
    // Most phases use short filters to keep the run quick; now and then a
    // block runs past the history depth, a tap word lands inside a block, or
    // a block is left open so the next tap count applies mid-block.
    random_end = words_queued + RANDOM_WORDS;
    while (words_queued < random_end) begin
      case ($urandom_range(0, 9))
        0:       m = 0;
        1:       m = $urandom_range(NTAPS + 1, 63);
        2, 3:    m = $urandom_range(17, NTAPS);
        default: m = $urandom_range(1, 16);
      endcase
      write_tap_count(m);
      eff = (m < 1) ? 1 : (m > NTAPS) ? NTAPS : m;
      lag = (eff - 1) / 2;

      if ($urandom_range(0, 2) == 0) begin
        // Scaled taps keep many outputs inside range; shift 0 keeps extremes.
        shift = $urandom_range(0, 5);
        for (int i = 0; i < eff; i++)
          queue_tap(i, pick_q15() >>> shift, pick_q15() >>> shift, $urandom_range(0, 1));
      end

      repeat ($urandom_range(1, 3)) begin
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(NTAPS + 1, NTAPS + 8)
                                           : $urandom_range(1, 2 * lag + 3);
        open = ($urandom_range(0, 5) == 0);
        for (int s = 0; s < len; s++) begin
          if ($urandom_range(0, 11) == 0)
            queue_tap($urandom_range(0, NTAPS - 1), pick_q15(), pick_q15(), $urandom_range(0, 1));
          queue_sample(pick_q15(), pick_q15(), s == len - 1 && !open);
        end
      end
    end
    // Close whatever block may still be open.
    queue_sample(pick_q15(), pick_q15(), 1'b1);

    drain();

    $display("Drove %0d words: %0d tap loads and %0d samples in %0d blocks, tap counts 0 to 63.",
             words_taken, taps_taken, samples_taken, blocks_taken);
    $display("Checked %0d filtered words, %0d of them clipped, %0d mismatches.",
             results_checked, sat_seen, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
